// File: hw/rtl/ebl_pkg.sv
// Shared widths, register indexes and fixed-point constants for the
// encoder-to-brightness-level block. No dependencies.
package ebl_pkg;

   // Field and register widths
   localparam int COUNT_W   = 16;
   localparam int PERIOD_W  = 17;
   localparam int LEVEL_W   = 16;
   localparam int PCT_W     = 7;
   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 2;

   // Datapath widths
   localparam int DIFF_W  = COUNT_W + 1;          // raw sample difference
   localparam int DELTA_W = PERIOD_W + 2;         // unwrapped difference
   localparam int MUL_W   = DELTA_W + LEVEL_W + 1; // delta times top level
   localparam int ACC_W   = 21;                  // fine accumulator
   localparam int SUM_W   = MUL_W + 1;
   localparam int PROD_W  = LEVEL_W + PCT_W;     // pwm top times percent
   localparam int RECIP_W = 47;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENCODER_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_TOP        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_PERCENT  = 2'd2;

   // Register reset values
   localparam logic [PERIOD_W-1:0] ENCODER_PERIOD_RST = 17'd65536;
   localparam logic [LEVEL_W-1:0]  PWM_TOP_RST        = 16'd65535;
   localparam logic [PCT_W-1:0]    LIMIT_PERCENT_RST  = 7'd100;
   localparam logic [PCT_W-1:0]    PERCENT_FULL       = 7'd100;

   // Detents per full turn
   localparam int STEPS_PER_TURN = 20;

   // x / 100 = (x * RECIP_100) >> 30, exact for x < 2^23
   localparam logic [RECIP_W-1:0] RECIP_100       = 47'd10737419;
   localparam int                 RECIP_100_SHIFT = 30;
   // x / 20 = (x * RECIP_STEPS) >> 26, exact for x < 2^22
   localparam logic [RECIP_W-1:0] RECIP_STEPS       = 47'd3355444;
   localparam int                 RECIP_STEPS_SHIFT = 26;

   // Derived values at reset configuration
   localparam logic [PROD_W-1:0]  PROD_RST   = 23'd6553500;
   localparam logic [LEVEL_W-1:0] TOP_RST    = 16'd65535;
   localparam logic [ACC_W-1:0]   ACCMAX_RST = 21'd1310700;

endpackage

// File: hw/rtl/encoder_to_brightness_level_top.sv
// Encoder-to-brightness-level block: six-stage pipeline with an
// accumulator loop. Depends on ebl_pkg.
//
// Throughput: one transaction per cycle while rsp_stall is low; the loops are
//   the stage 1 previous sample and the stage 4 accumulator (an add and a saturate).
// Stages with a bubble are filled while the output waits, so req_stall is
//   raised only when all six stages hold transactions and rsp_stall is high.
// Reset (synchronous, active high): registers go to their defaults, the
//   previous sample and the accumulator go to zero, and the pipeline empties.
module encoder_to_brightness_level_top (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ebl_pkg::COUNT_W-1:0]     req_encoder_count,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ebl_pkg::LEVEL_W-1:0]     rsp_level,
   // register write port
   input  logic                            csr_we,
   input  logic [ebl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ebl_pkg::CSR_W-1:0]       csr_wdata
);
   import ebl_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers and the values derived from them.
   // top_ff is derived from prod_ff and accmax_ff from top_ff. The
   // pipeline reads top_ff first on entry to stage 3 and accmax_ff on
   // entry to stage 4, so the first transaction after a write already
   // sees them.
   // ---------------------------------------------------------------
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [LEVEL_W-1:0]  pwm_top_ff, pwm_top_in;
   logic [PCT_W-1:0]    pct_ff, pct_in;
   logic [PCT_W-1:0]    pct_sat;
   logic [PROD_W-1:0]   prod_ff, prod_in;      // pwm_top * percent
   logic [RECIP_W-1:0]  top_prod;
   logic [LEVEL_W-1:0]  top_ff, top_in;        // limited full-scale level
   logic [ACC_W-1:0]    accmax_ff, accmax_in;  // top * steps per turn

   // ---------------------------------------------------------------
   // Pipeline stages
   //   s1: raw difference to previous sample
   //   s2: difference unwrapped against half the period
   //   s3: difference times top level
   //   s4: saturating accumulator (a state loop, like the previous sample)
   //   s5: rounded divide by steps per turn
   //   s6: clamp to top level, result register
   // ---------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in, s5_valid_in, rsp_valid_in;
   logic room1, room2, room3, room4, room5, room6;

   logic [COUNT_W-1:0]        prev_count_ff, prev_count_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [DELTA_W-1:0] diff_ext, half_s, period_s;
   logic signed [MUL_W-1:0]   mul_ff, mul_in;
   logic signed [SUM_W-1:0]   sum;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [ACC_W:0]            rnd;
   logic [RECIP_W-1:0]        quot_prod;
   logic [LEVEL_W-1:0]        quot_ff, quot_in;
   logic [LEVEL_W-1:0]        rsp_level_ff, rsp_level_in;

   logic accept;

   // A stage can load when it is empty or its contents move on.
   always_comb begin
      room6 = !rsp_valid_ff || !rsp_stall;
      room5 = !s5_valid_ff || room6;
      room4 = !s4_valid_ff || room5;
      room3 = !s3_valid_ff || room4;
      room2 = !s2_valid_ff || room3;
      room1 = !s1_valid_ff || room2;
   end

   assign req_stall = !room1;
   assign accept    = req_valid && room1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

   // Register writes; an unused index is dropped.
   always_comb begin
      period_in  = period_ff;
      pwm_top_in = pwm_top_ff;
      pct_in     = pct_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENCODER_PERIOD: period_in  = csr_wdata[PERIOD_W-1:0];
            CSR_PWM_TOP:        pwm_top_in = csr_wdata[LEVEL_W-1:0];
            CSR_LIMIT_PERCENT:  pct_in     = csr_wdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // Top level = pwm_top * min(percent, 100) / 100, by reciprocal multiply.
   always_comb begin
      pct_sat   = (pct_ff > PERCENT_FULL) ? PERCENT_FULL : pct_ff;
      prod_in   = PROD_W'(pwm_top_ff) * PROD_W'(pct_sat);
      top_prod  = RECIP_W'(prod_ff) * RECIP_100;
      top_in    = top_prod[RECIP_100_SHIFT +: LEVEL_W];
      accmax_in = ACC_W'(top_ff) * ACC_W'(STEPS_PER_TURN);
   end

   // Datapath
   always_comb begin
      // s1: difference, previous sample follows every accepted transaction
      diff_in       = $signed({1'b0, req_encoder_count}) - $signed({1'b0, prev_count_ff});
      prev_count_in = accept ? req_encoder_count : prev_count_ff;

      // s2: unwrap
      diff_ext = {{(DELTA_W-DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
      period_s = $signed({{(DELTA_W-PERIOD_W){1'b0}}, period_ff});
      half_s   = $signed({{(DELTA_W-PERIOD_W+1){1'b0}}, period_ff[PERIOD_W-1:1]});
      if (diff_ext > half_s) begin
         delta_in = diff_ext - period_s;
      end else if (diff_ext < -half_s) begin
         delta_in = diff_ext + period_s;
      end else begin
         delta_in = diff_ext;
      end

      // s3: scale by top level
      mul_in = delta_ff * $signed({1'b0, top_ff});

      // s4: accumulate and saturate at 0 and top * steps
      sum = $signed({{(SUM_W-ACC_W){1'b0}}, acc_ff}) + $signed({mul_ff[MUL_W-1], mul_ff});
      if (sum < 0) begin
         acc_in = '0;
      end else if (sum > $signed({{(SUM_W-ACC_W){1'b0}}, accmax_ff})) begin
         acc_in = accmax_ff;
      end else begin
         acc_in = sum[ACC_W-1:0];
      end
      if (!(room4 && s3_valid_ff)) begin
         acc_in = acc_ff;
      end

      // s5: round half up, divide by steps per turn
      rnd       = {1'b0, acc_ff} + (ACC_W+1)'(STEPS_PER_TURN / 2);
      quot_prod = RECIP_W'(rnd) * RECIP_STEPS;
      quot_in   = quot_prod[RECIP_STEPS_SHIFT +: LEVEL_W];

      // s6: clamp to top level
      rsp_level_in = (quot_ff > top_ff) ? top_ff : quot_ff;
   end

   // Valid bits
   always_comb begin
      s1_valid_in  = room1 ? req_valid    : s1_valid_ff;
      s2_valid_in  = room2 ? s1_valid_ff  : s2_valid_ff;
      s3_valid_in  = room3 ? s2_valid_ff  : s3_valid_ff;
      s4_valid_in  = room4 ? s3_valid_ff  : s4_valid_ff;
      s5_valid_in  = room5 ? s4_valid_ff  : s5_valid_ff;
      rsp_valid_in = room6 ? s5_valid_ff  : rsp_valid_ff;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= ENCODER_PERIOD_RST;
         pwm_top_ff    <= PWM_TOP_RST;
         pct_ff        <= LIMIT_PERCENT_RST;
         prod_ff       <= PROD_RST;
         top_ff        <= TOP_RST;
         accmax_ff     <= ACCMAX_RST;
         prev_count_ff <= '0;
         acc_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         s5_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         period_ff     <= period_in;
         pwm_top_ff    <= pwm_top_in;
         pct_ff        <= pct_in;
         prod_ff       <= prod_in;
         top_ff        <= top_in;
         accmax_ff     <= accmax_in;
         prev_count_ff <= prev_count_in;
         acc_ff        <= acc_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         s3_valid_ff   <= s3_valid_in;
         s4_valid_ff   <= s4_valid_in;
         s5_valid_ff   <= s5_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (room1) begin
         diff_ff <= diff_in;
      end
      if (room2) begin
         delta_ff <= delta_in;
      end
      if (room3) begin
         mul_ff <= mul_in;
      end
      if (room5) begin
         quot_ff <= quot_in;
      end
      if (room6) begin
         rsp_level_ff <= rsp_level_in;
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // Input is held off only when every stage is occupied and the output waits.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff
                     && s5_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("req_stall raised with room in the pipeline");

   // An accepted transaction lands in stage 1.
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction missing from stage 1");

   // Previous sample tracks the last accepted transaction.
   a_prev_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> (prev_count_ff == $past(req_encoder_count)))
      else $error("previous sample not updated");

   // Accumulator moves only when a transaction enters stage 4.
   a_acc_moves_on_entry: assert property (@(posedge clock) disable iff (reset)
      !(room4 && s3_valid_ff) |=> $stable(acc_ff))
      else $error("accumulator changed without a transaction");

endmodule
